FILE: rtl/tsb_pkg.sv
package tsb_pkg;

	localparam int MAX_SIDE = 256;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	localparam logic [1:0] KIND_CHECKER = 2'd0;
	localparam logic [1:0] KIND_IMAGE   = 2'd1;
	localparam logic [1:0] KIND_MISSING = 2'd2;
	localparam logic [1:0] KIND_WHITE   = 2'd3;

	localparam logic [2:0] REG_KIND   = 3'd0;
	localparam logic [2:0] REG_FILTER = 3'd1;
	localparam logic [2:0] REG_WIDTH  = 3'd2;
	localparam logic [2:0] REG_HEIGHT = 3'd3;
	localparam logic [2:0] REG_SCALE  = 3'd4;
	localparam logic [2:0] REG_OFFSET = 3'd5;
	localparam logic [2:0] REG_DARK   = 3'd6;
	localparam logic [2:0] REG_LIGHT  = 3'd7;

	localparam logic [23:0] COLOR_MAGENTA = 24'hFF00FF;
	localparam logic [23:0] COLOR_WHITE   = 24'hFFFFFF;

	// Blend of two 8-bit values by a 9-bit weight out of 256.
	function automatic logic [15:0] lerp8(input logic [7:0] a, input logic [7:0] b,
			input logic [8:0] w);
		logic [16:0] s;
		s = {9'd0, a} * (17'd256 - {8'd0, w}) + {9'd0, b} * {8'd0, w};
		return s[15:0];
	endfunction

endpackage

FILE: rtl/texture_sampler_bilinear_checker.sv
// Texture sampler with a banked texel store, nearest or bilinear filter,
// a 3-D checkerboard and constant colors.
//
// Input channel (in_valid/in_stall): operation 1 writes texel_rgb at
// (texel_col, texel_row) and gives no result; operation 0 samples and gives
// one red/green/blue result on the output channel (out_valid/out_stall).
// Configuration is to be written through cfg_we/cfg_index/cfg_data only
// while idle; the user must keep to this, as the block does not enforce it.
// One item enters every cycle while the output is not stalled. A sample's
// result is presented through five registers: position products, store
// read, two blend stages and the output register.
// The store is split into four banks by column and row parity so that the
// four bilinear neighbors are read in the same cycle.
//
// Reset clears the pipeline valid bits and loads the register defaults.
// The texel store is not cleared; read texels only after writing them.
// A stall on the output freezes the whole pipeline; in_stall follows it.
module texture_sampler_bilinear_checker import tsb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [0:0]  operation,
	input  logic [31:0] u_coord,
	input  logic [31:0] v_coord,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic [7:0]  texel_col,
	input  logic [7:0]  texel_row,
	input  logic [23:0] texel_rgb,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	localparam int SB = $clog2(MAX_SIDE);
	localparam int HB = SB - 1;
	localparam int BAW = 2 * HB;
	localparam int SW = SB + 1;

	logic [1:0]  kind_q;
	logic        filter_q;
	logic [8:0]  width_q, height_q;
	logic [15:0] scale_q;
	logic [31:0] offset_q;
	logic [23:0] dark_q, light_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_IMAGE;
			filter_q <= 1'b0;
			width_q <= 9'd256;
			height_q <= 9'd256;
			scale_q <= 16'd256;
			offset_q <= '0;
			dark_q <= '0;
			light_q <= 24'hFFFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KIND:   kind_q <= cfg_data[1:0];
				REG_FILTER: filter_q <= cfg_data[0];
				REG_WIDTH:  width_q <= cfg_data[8:0];
				REG_HEIGHT: height_q <= cfg_data[8:0];
				REG_SCALE:  scale_q <= cfg_data[15:0];
				REG_OFFSET: offset_q <= cfg_data;
				REG_DARK:   dark_q <= cfg_data[23:0];
				REG_LIGHT:  light_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Effective sizes, 1..MAX_SIDE.
	logic [SW-1:0] w_eff, h_eff;
	always_comb begin
		if (width_q == 9'd0) w_eff = SW'(1);
		else if (width_q > 9'(MAX_SIDE)) w_eff = SW'(MAX_SIDE);
		else w_eff = SW'(width_q);
		if (height_q == 9'd0) h_eff = SW'(1);
		else if (height_q > 9'(MAX_SIDE)) h_eff = SW'(MAX_SIDE);
		else h_eff = SW'(height_q);
	end

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	// Stage 1: texel position products.
	logic [16+SW-1:0] xp_s1, yp_s1;
	logic             smp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_xfer && (operation == OP_SAMPLE);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s1 <= u_coord[15:0] * w_eff;
			yp_s1 <= v_coord[15:0] * h_eff;
			smp_s1 <= in_valid;
		end
	end

	// Texel writes go straight into the store.
	logic write_en;
	assign write_en = in_xfer && (operation == OP_WRITE)
		&& ({1'b0, texel_col} < 9'(MAX_SIDE)) && ({1'b0, texel_row} < 9'(MAX_SIDE));

	// Address computation from stage 1 values.
	logic [16+SW-1:0] sx, sy;
	logic signed [SW+1:0] xl, yl, x1i, y1i;
	logic [SB-1:0] x0, x1, y0, y1, xn, yn;
	logic [SB-1:0] cx0, cx1, cy0, cy1;
	logic [7:0] wx, wy;

	function automatic logic [SB-1:0] clampi(input logic signed [SW+1:0] i,
			input logic [SW-1:0] n);
		if (i < 0) return '0;
		if (i >= $signed({2'b00, n})) return SB'(n - SW'(1));
		return i[SB-1:0];
	endfunction

	always_comb begin
		sx = xp_s1 + (16+SW)'(32'h8000);
		sy = yp_s1 + (16+SW)'(32'h8000);
		xl = $signed({2'b00, sx[16+SW-1:16]}) - (SW+2)'(1);
		yl = $signed({2'b00, sy[16+SW-1:16]}) - (SW+2)'(1);
		x1i = xl + (SW+2)'(1);
		y1i = yl + (SW+2)'(1);
		wx = sx[15:8];
		wy = sy[15:8];
		xn = (xp_s1[16+SW-1:16] > w_eff - SW'(1)) ? SB'(w_eff - SW'(1)) : SB'(xp_s1[16+SW-1:16]);
		yn = (yp_s1[16+SW-1:16] > h_eff - SW'(1)) ? SB'(h_eff - SW'(1)) : SB'(yp_s1[16+SW-1:16]);
		if (filter_q) begin
			x0 = clampi(xl, w_eff); x1 = clampi(x1i, w_eff);
			y0 = clampi(yl, h_eff); y1 = clampi(y1i, h_eff);
		end else begin
			x0 = xn; x1 = xn; y0 = yn; y1 = yn;
		end
		// Order the pair by parity so each bank gets exactly one address.
		cx0 = x0[0] ? x1 : x0;
		cx1 = x0[0] ? x0 : x1;
		cy0 = y0[0] ? y1 : y0;
		cy1 = y0[0] ? y0 : y1;
	end

	// Stage 2: bank reads; bank index {row parity, column parity}.
	logic [23:0] bank_q [4];
	logic [BAW-1:0] raddr [4];
	logic [7:0] wx_s2, wy_s2;
	logic       xs_s2, ys_s2, filt_s2, xeq_s2, yeq_s2;
	logic [1:0] kind_s2;

	assign raddr[0] = {cy0[SB-1:1], cx0[SB-1:1]};
	assign raddr[1] = {cy0[SB-1:1], cx1[SB-1:1]};
	assign raddr[2] = {cy1[SB-1:1], cx0[SB-1:1]};
	assign raddr[3] = {cy1[SB-1:1], cx1[SB-1:1]};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic we_b;
		assign we_b = write_en && (texel_col[0] == b[0]) && (texel_row[0] == b[1]);
		tsb_texel_bank #(.AW(BAW)) u_bank (
			.clk(clk), .we(we_b),
			.waddr({texel_row[SB-1:1], texel_col[SB-1:1]}),
			.wdata(texel_rgb), .re(adv), .raddr(raddr[b]), .rdata(bank_q[b])
		);
	end

	logic px, py, pz;
	tsb_checker_bit u_cx (.clk(clk), .en(adv), .coord(point_x), .offset(offset_q),
		.scale(scale_q), .parity(px));
	tsb_checker_bit u_cy (.clk(clk), .en(adv), .coord(point_y), .offset(offset_q),
		.scale(scale_q), .parity(py));
	tsb_checker_bit u_cz (.clk(clk), .en(adv), .coord(point_z), .offset(offset_q),
		.scale(scale_q), .parity(pz));

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s2 <= filter_q ? wx : 8'd0;
			wy_s2 <= filter_q ? wy : 8'd0;
			xs_s2 <= x0[0];
			ys_s2 <= y0[0];
			xeq_s2 <= (x0 == x1);
			yeq_s2 <= (y0 == y1);
			filt_s2 <= smp_s1;
			kind_s2 <= kind_q;
		end
	end

	// Stage 3: horizontal blends. A neighbor clamped onto the same texel
	// takes the value read for that texel, not the other bank's entry.
	logic [23:0] c00, c10, c01, c11;
	always_comb begin
		c00 = bank_q[{ys_s2, xs_s2}];
		c10 = xeq_s2 ? c00 : bank_q[{ys_s2, !xs_s2}];
		c01 = yeq_s2 ? c00 : bank_q[{!ys_s2, xs_s2}];
		c11 = xeq_s2 ? c01 : (yeq_s2 ? c10 : bank_q[{!ys_s2, !xs_s2}]);
	end

	logic [15:0] bot_s3 [3];
	logic [15:0] top_s3 [3];
	logic [7:0]  wy_s3;
	logic [23:0] alt_s3;
	logic        img_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				bot_s3[k] <= lerp8(c00[8*k +: 8], c10[8*k +: 8], {1'b0, wx_s2});
				top_s3[k] <= lerp8(c01[8*k +: 8], c11[8*k +: 8], {1'b0, wx_s2});
			end
			wy_s3 <= wy_s2;
			img_s3 <= (kind_s2 == KIND_IMAGE) && filt_s2;
			// The checker parity registers line up with the second stage.
			case (kind_s2)
				KIND_CHECKER: alt_s3 <= (px ^ py ^ pz) ? dark_q : light_q;
				KIND_MISSING: alt_s3 <= COLOR_MAGENTA;
				default:      alt_s3 <= COLOR_WHITE;
			endcase
		end
	end

	// Stage 4: vertical blend and rounding.
	logic [23:0] col_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				logic [24:0] acc;
				acc = {9'd0, bot_s3[k]} * (25'd256 - {17'd0, wy_s3})
					+ {9'd0, top_s3[k]} * {17'd0, wy_s3} + 25'd32768;
				col_s4[8*k +: 8] <= img_s3 ? (acc[24] ? 8'hFF : acc[23:16]) : alt_s3[8*k +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red <= col_s4[23:16];
			green <= col_s4[15:8];
			blue <= col_s4[7:0];
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(blue))
		else $error("result changed under stall");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s4 |=> out_valid)
		else $error("sample lost in last stage");
endmodule

FILE: rtl/tsb_checker_bit.sv
// Parity of the checker cell index for one coordinate, two register stages.
module tsb_checker_bit import tsb_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] coord,
	input  logic [31:0] offset,
	input  logic [15:0] scale,
	output logic        parity
);
	logic signed [32:0] sum_s1;
	logic signed [49:0] prod;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= $signed({coord[31], coord}) + $signed({offset[31], offset});
		end
	end

	assign prod = sum_s1 * $signed({1'b0, scale});

	always_ff @(posedge clk) begin
		if (en) begin
			parity <= prod[24];
		end
	end
endmodule

FILE: rtl/tsb_texel_bank.sv
// One parity bank of the texel store: one write port, one registered read port.
module tsb_texel_bank #(
	parameter int AW = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [23:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [23:0]   rdata
);
	logic [23:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
